/* hw/rtl/ndpr_pkg.sv */
// shared types, sizes and codes for near-duplicate point removal
package ndpr_pkg;

  // store size and derived widths
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // field widths
  localparam int COORD_W = 32;
  localparam int TOL_W   = 31;
  localparam int SQ_W    = 2 * TOL_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int PT_W    = 3 * COORD_W;

  // input item
  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
    logic                      list_end;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      kept;
    logic                      overflow;
    logic                      out_last;
  } out_item_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic issue_last;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/near_duplicate_point_removal_top.sv */
// each input transfer is compared against the n points kept so far in the list (0 to 64),
// reading the store once per cycle through the single read port of the point ram into a
// four-stage compare pipe; with an empty store the scan is skipped. A new point is taken
// only once the result of the last one has been committed to the output register
// reset: synchronous active low; clears tolerance, kept count and control, store untouched
module near_duplicate_point_removal_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ndpr_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ndpr_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ndpr_pkg::TOL_W-1:0]    cfg_data
);

  ndpr_pkg::cmd_t    cmd;
  ndpr_pkg::status_t status;

  // sequencing
  ndpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // store and compare datapath
  ndpr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

endmodule

/* hw/rtl/ndpr_ram.sv */
// generic single-write, single-read ram with registered read data
module ndpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ndpr_ctrl.sv */
// controller state machine: accept, scan, drain and commit sequencing
module ndpr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ndpr_pkg::status_t status,
  output ndpr_pkg::cmd_t    cmd
);

  ndpr_pkg::state_t state_r;
  ndpr_pkg::state_t state_nxt;
  logic             in_fire;

  assign in_fire = in_valid && !in_stall;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ndpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ndpr_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = status.cnt_zero ? ndpr_pkg::ST_DONE : ndpr_pkg::ST_SCAN;
        end
      end
      ndpr_pkg::ST_SCAN: begin
        if (status.issue_last) begin
          state_nxt = ndpr_pkg::ST_DRAIN;
        end
      end
      ndpr_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ndpr_pkg::ST_DONE;
        end
      end
      ndpr_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ndpr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ndpr_pkg::ST_IDLE;
    endcase
  end

  // outputs, input held off while in reset
  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ndpr_pkg::ST_IDLE: begin
        in_stall = !rst_n;
        cmd.load = in_valid && rst_n;
      end
      ndpr_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      ndpr_pkg::ST_DRAIN: begin
        cmd.issue = 1'b0;
      end
      ndpr_pkg::ST_DONE: begin
        cmd.commit = status.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // an accepted point always leaves idle
  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ndpr_pkg::ST_IDLE)
    else $error("accepted point did not start processing");

  // commit only once the compare pipeline is empty
  a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !status.pipe_busy)
    else $error("commit with comparisons still in flight");

endmodule

/* hw/rtl/ndpr_dp.sv */
// datapath: point store, pipelined distance compare, count and output register
module ndpr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ndpr_pkg::cmd_t                cmd,
  output ndpr_pkg::status_t             status,
  input  ndpr_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ndpr_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ndpr_pkg::TOL_W-1:0]    cfg_data
);

  localparam int CW = ndpr_pkg::COORD_W;
  localparam int TW = ndpr_pkg::TOL_W;

  // configuration and per-point registers
  logic [TW-1:0]                      tol_r;
  logic [ndpr_pkg::SQ_W-1:0]          tolsq_r;
  ndpr_pkg::in_item_t                 pt_r;
  logic [ndpr_pkg::CNT_W-1:0]         cnt_r;
  logic [ndpr_pkg::CNT_W-1:0]         cnt_nxt;
  logic [ndpr_pkg::CNT_W-1:0]         rd_idx_r;
  logic [ndpr_pkg::CNT_W-1:0]         rd_idx_nxt;
  logic                               hit_r;
  logic                               hit_nxt;

  // compare pipeline
  logic                               v1_r, v2_r, v3_r, v4_r;
  logic [ndpr_pkg::PT_W-1:0]          rd_data;
  logic [CW-1:0]                      kx, ky, kz;
  logic signed [CW:0]                 dx, dy, dz;
  logic [CW:0]                        ax, ay, az;
  logic                               far;
  logic [TW-1:0]                      ax2_r, ay2_r, az2_r;
  logic                               far2_r, far3_r, far4_r;
  logic [ndpr_pkg::SQ_W-1:0]          sqx3_r, sqy3_r, sqz3_r;
  logic [ndpr_pkg::SUM_W-1:0]         sum4_r;

  // store write and output
  logic                               full;
  logic                               we;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  ndpr_pkg::out_item_t                out_r;

  assign cfg_ready = rst_n;
  assign full      = (cnt_r == ndpr_pkg::CNT_W'(ndpr_pkg::MAX_POINTS));
  assign we        = cmd.commit && !hit_r && !full;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // latch the point and the squared tolerance on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_r    <= in_data;
      tolsq_r <= tol_r * tol_r;
    end
  end

  // kept point store, x y z packed in one word
  ndpr_ram #(
    .WIDTH (ndpr_pkg::PT_W),
    .DEPTH (ndpr_pkg::MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[ndpr_pkg::IDX_W-1:0]),
    .wdata ({pt_r.x_coord, pt_r.y_coord, pt_r.z_coord}),
    .raddr (rd_idx_r[ndpr_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  // read index walks the kept entries
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.load) begin
      rd_idx_nxt = '0;
    end else if (cmd.issue) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // stage 1: absolute axis differences and early reject
  assign kx = rd_data[3*CW-1:2*CW];
  assign ky = rd_data[2*CW-1:CW];
  assign kz = rd_data[CW-1:0];

  always_comb begin
    dx  = $signed({pt_r.x_coord[CW-1], pt_r.x_coord}) - $signed({kx[CW-1], kx});
    dy  = $signed({pt_r.y_coord[CW-1], pt_r.y_coord}) - $signed({ky[CW-1], ky});
    dz  = $signed({pt_r.z_coord[CW-1], pt_r.z_coord}) - $signed({kz[CW-1], kz});
    ax  = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    ay  = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
    az  = dz[CW] ? (CW+1)'(-dz) : (CW+1)'(dz);
    far = (ax > {2'b00, tol_r}) || (ay > {2'b00, tol_r}) || (az > {2'b00, tol_r});
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    ax2_r  <= ax[TW-1:0];
    ay2_r  <= ay[TW-1:0];
    az2_r  <= az[TW-1:0];
    far2_r <= far;
    // stage 2: squares
    sqx3_r <= ax2_r * ax2_r;
    sqy3_r <= ay2_r * ay2_r;
    sqz3_r <= az2_r * az2_r;
    far3_r <= far2_r;
    // stage 3: sum of squares
    sum4_r <= {2'b00, sqx3_r} + {2'b00, sqy3_r} + {2'b00, sqz3_r};
    far4_r <= far3_r;
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage 4: compare against squared tolerance, sticky duplicate flag
  always_comb begin
    hit_nxt = hit_r;
    if (cmd.load) begin
      hit_nxt = 1'b0;
    end else if (v4_r && !far4_r && (sum4_r <= {2'b00, tolsq_r})) begin
      hit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  // kept count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.commit) begin
      if (pt_r.list_end) begin
        cnt_nxt = '0;
      end else if (we) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.out_x    <= pt_r.x_coord;
      out_r.out_y    <= pt_r.y_coord;
      out_r.out_z    <= pt_r.z_coord;
      out_r.kept     <= !hit_r;
      out_r.overflow <= !hit_r && full;
      out_r.out_last <= pt_r.list_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status to controller
  assign status.cnt_zero   = (cnt_r == '0);
  assign status.issue_last = ((rd_idx_r + 1'b1) == cnt_r);
  assign status.pipe_busy  = v1_r || v2_r || v3_r || v4_r;
  assign status.out_free   = !out_valid_r || !out_stall;

  // count stays within the store
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ndpr_pkg::CNT_W'(ndpr_pkg::MAX_POINTS))
    else $error("kept count beyond store size");

  // reads only touch written entries
  a_read_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> rd_idx_r < cnt_r)
    else $error("read of an entry that was never written");

  // a duplicate is never flagged overflow
  a_ovf_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.kept || !out_r.overflow))
    else $error("overflow set on a dropped point");

endmodule

/* verif/near_duplicate_point_removal_top_tb.sv */
// self-checking testbench for the near-duplicate point removal block
module near_duplicate_point_removal_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ndpr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ndpr_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ndpr_pkg::TOL_W-1:0] cfg_data = '0;

  // points waiting to be sent and results still owed by the block
  ndpr_pkg::in_item_t pending_pts[$];
  ndpr_pkg::out_item_t awaited_q[$];

  // shadow of the tolerance register and of the kept-point store
  logic [ndpr_pkg::TOL_W-1:0] tol_shadow = '0;
  logic [ndpr_pkg::COORD_W-1:0] kept_xs[ndpr_pkg::MAX_POINTS];
  logic [ndpr_pkg::COORD_W-1:0] kept_ys[ndpr_pkg::MAX_POINTS];
  logic [ndpr_pkg::COORD_W-1:0] kept_zs[ndpr_pkg::MAX_POINTS];
  int stored_n = 0;

  int mismatches = 0;
  int cycles = 0;
  bit took = 0;
  bit hold = 0;
  int tx_burst = 0;
  int tx_gap = 0;
  int rx_mode = 0;
  int rx_span = 0;

  near_duplicate_point_removal_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // absolute difference of two signed coordinates, widened
  function automatic logic [63:0] axis_gap(logic [31:0] a, logic [31:0] b);
    logic signed [33:0] d;
    d = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
    if (d < 0) d = -d;
    return {30'b0, d};
  endfunction

  // exact squared-distance test against one stored point
  function automatic logic near_point(ndpr_pkg::in_item_t p, int i,
                                      logic [ndpr_pkg::TOL_W-1:0] tol);
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] dz;
    logic [63:0] t;
    dx = axis_gap(p.x_coord, kept_xs[i]);
    dy = axis_gap(p.y_coord, kept_ys[i]);
    dz = axis_gap(p.z_coord, kept_zs[i]);
    t = {33'b0, tol};
    if (dx > t || dy > t || dz > t) return 1'b0;
    return (dx * dx + dy * dy + dz * dz) <= t * t;
  endfunction

  // decide keep/drop/overflow for one point and update the shadow store
  function automatic ndpr_pkg::out_item_t classify_point(ndpr_pkg::in_item_t p);
    ndpr_pkg::out_item_t r;
    logic hit;
    int n;
    n = stored_n;
    hit = 1'b0;
    for (int i = 0; i < n && !hit; i++)
      if (near_point(p, i, tol_shadow)) hit = 1'b1;
    r.out_x = p.x_coord;
    r.out_y = p.y_coord;
    r.out_z = p.z_coord;
    r.kept = !hit;
    r.overflow = 1'b0;
    r.out_last = p.list_end;
    if (!hit) begin
      if (n < ndpr_pkg::MAX_POINTS) begin
        kept_xs[n] = p.x_coord;
        kept_ys[n] = p.y_coord;
        kept_zs[n] = p.z_coord;
        stored_n = n + 1;
      end else begin
        r.overflow = 1'b1;
      end
    end
    if (p.list_end) stored_n = 0;
    return r;
  endfunction

  // coordinate either fully random or on a grid spaced by the tolerance
  function automatic logic [31:0] rand_coord(logic [ndpr_pkg::TOL_W-1:0] tol);
    int k;
    k = int'($urandom_range(0, 6)) - 3;
    if ($urandom_range(0, 1)) return $urandom();
    return k * int'({1'b0, tol});
  endfunction

  // offset around the tolerance, both signs, boundary and one past it
  function automatic logic [31:0] jitter(logic [ndpr_pkg::TOL_W-1:0] tol);
    logic [31:0] mag;
    case ($urandom_range(0, 4))
      0: mag = '0;
      1: mag = {1'b0, tol};
      2: mag = {1'b0, tol} + 32'd1;
      3: mag = $urandom_range(0, tol);
      default: mag = {2'b0, tol[ndpr_pkg::TOL_W-1:1]};
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic push_pt(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    ndpr_pkg::in_item_t p;
    p.x_coord = x;
    p.y_coord = y;
    p.z_coord = z;
    p.list_end = last;
    pending_pts.insert(pending_pts.size(), p);
  endtask

  // one list of random points, with copies and near copies of earlier ones
  task automatic queue_list(int len, logic [ndpr_pkg::TOL_W-1:0] tol);
    ndpr_pkg::in_item_t seen[$];
    ndpr_pkg::in_item_t pt;
    ndpr_pkg::in_item_t base;
    int pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (seen.size() == 0 || pick < 4) begin
        pt.x_coord = rand_coord(tol);
        pt.y_coord = rand_coord(tol);
        pt.z_coord = rand_coord(tol);
      end else begin
        base = seen[$urandom_range(0, seen.size() - 1)];
        pt = base;
        if (pick >= 6) begin
          if ($urandom_range(0, 1)) pt.x_coord = base.x_coord + jitter(tol);
          if ($urandom_range(0, 1)) pt.y_coord = base.y_coord + jitter(tol);
          if ($urandom_range(0, 1)) pt.z_coord = base.z_coord + jitter(tol);
        end
      end
      pt.list_end = (i == len - 1);
      seen.insert(seen.size(), pt);
      pending_pts.insert(pending_pts.size(), pt);
    end
  endtask

  // wait until nothing is in flight, then let the pipeline go quiet
  task automatic settle();
    while (pending_pts.size() != 0 || in_valid || awaited_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [ndpr_pkg::TOL_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tol_shadow = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // input transfer: predict the result and retire the point
  always @(posedge clk) begin
    took = rst_n && in_valid && !in_stall;
    if (took) begin
      awaited_q.insert(awaited_q.size(), classify_point(in_data));
      void'(pending_pts.pop_front());
    end
  end

  // sender: bursts with random gaps, payload held while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !took) begin
      // hold the stalled transfer
    end else if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      in_valid <= 1'b0;
    end else if (hold || pending_pts.size() == 0) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= 1'b1;
      in_data <= pending_pts[0];
      if (tx_burst > 1) begin
        tx_burst <= tx_burst - 1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            tx_burst <= $urandom_range(20, 60);
            tx_gap <= 0;
          end
          9: begin
            tx_burst <= 1;
            tx_gap <= $urandom_range(30, 120);
          end
          default: begin
            tx_burst <= $urandom_range(1, 4);
            tx_gap <= $urandom_range(1, 6);
          end
        endcase
      end
    end
  end

  // receiver stall pattern: none, moderate or heavy, in stretches
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_span <= $urandom_range(20, 200);
      out_stall <= 1'b0;
    end else begin
      rx_span <= rx_span - 1;
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 99) < 85);
      endcase
    end
  end

  // result transfer: compare with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        check_field("out_x", awaited_q[0].out_x, out_data.out_x);
        check_field("out_y", awaited_q[0].out_y, out_data.out_y);
        check_field("out_z", awaited_q[0].out_z, out_data.out_z);
        check_field("kept", awaited_q[0].kept, out_data.kept);
        check_field("overflow", awaited_q[0].overflow, out_data.overflow);
        check_field("out_last", awaited_q[0].out_last, out_data.out_last);
        void'(awaited_q.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("near_duplicate_point_removal_top test failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [ndpr_pkg::TOL_W-1:0] phase_tol[6];
    int queued;
    int len;
    int half;

    // zero tolerance out of reset: only coincident points collide
    push_pt(32'h0, 32'h0, 32'h0, 1'b0);
    push_pt(32'h0, 32'h0, 32'h0, 1'b0);
    push_pt(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
    push_pt(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
    push_pt(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
    push_pt(32'h1, 32'h0, 32'h0, 1'b0);
    push_pt(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
    push_pt(32'hffffffff, 32'h0, 32'h1, 1'b1);
    // single-point list
    push_pt(32'h12345678, 32'hffffffff, 32'h0, 1'b1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // tolerance of 1.0: boundary on one axis, diagonal just inside and outside
    settle();
    write_tolerance(31'h10000);
    push_pt(32'h0, 32'h0, 32'h0, 1'b0);
    push_pt(32'h10000, 32'h0, 32'h0, 1'b0);
    push_pt(32'h0, 32'hffff0000, 32'h0, 1'b0);
    push_pt(32'h10001, 32'h0, 32'h0, 1'b0);
    push_pt(32'h8000, 32'h8000, 32'h8000, 1'b0);
    push_pt(32'h93cd, 32'h93cd, 32'h93cd, 1'b0);
    push_pt(32'h93ce, 32'h93ce, 32'h93ce, 1'b1);

    // widest tolerance against full-range coordinates
    settle();
    write_tolerance(31'h7fffffff);
    push_pt(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
    push_pt(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
    push_pt(32'h0, 32'h0, 32'h0, 1'b0);
    push_pt(32'h3fffffff, 32'h0, 32'h0, 1'b0);
    push_pt(32'hc0000000, 32'h40000000, 32'h0, 1'b1);

    // random phases, one tolerance each
    phase_tol[0] = 31'h7fffffff;
    phase_tol[1] = '0;
    phase_tol[2] = 31'h1;
    phase_tol[3] = ndpr_pkg::TOL_W'($urandom_range(1, 1 << 20));
    phase_tol[4] = 31'h10000;
    phase_tol[5] = ndpr_pkg::TOL_W'($urandom());
    for (int p = 0; p < 6; p++) begin
      settle();
      write_tolerance(phase_tol[p]);
      queued = 0;
      while (queued < 113) begin
        // long lists fill the store and run into overflow
        if (phase_tol[p] <= (1 << 20) && $urandom_range(0, 5) == 0)
          len = $urandom_range(65, 80);
        else
          len = $urandom_range(1, 12);
        queue_list(len, phase_tol[p]);
        queued += len;
      end
      // sender pause until every owed result is out
      if (p == 2) begin
        half = pending_pts.size() / 2;
        while (pending_pts.size() > half) @(posedge clk);
        hold = 1;
        while (in_valid || awaited_q.size() != 0) @(posedge clk);
        hold = 0;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("near_duplicate_point_removal_top test passed");
    end else begin
      $display("near_duplicate_point_removal_top test failed");
    end
    $finish;
  end

endmodule
